// ===== rtl/jpeg_marker_segment_scanner_assert.svh =====
// Assertion macros for the scanner RTL.
`ifndef JPEG_MARKER_SEGMENT_SCANNER_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define JMSS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jmss check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define JMSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jmss check failed");

`endif

// ===== rtl/jmss_pkg.sv =====
// Types and constants of the JPEG marker segment scanner.
`default_nettype none

package jmss_pkg;

	localparam int unsigned POS_WIDTH = 32;

	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [7:0] BYTE_00   = 8'h00;
	localparam logic [7:0] MRK_SOI   = 8'hD8;
	localparam logic [7:0] MRK_EOI   = 8'hD9;
	localparam logic [7:0] MRK_SOS   = 8'hDA;
	localparam logic [7:0] MRK_SOF0  = 8'hC0;
	localparam logic [7:0] MRK_DHT   = 8'hC4;
	localparam logic [7:0] MRK_DQT   = 8'hDB;
	localparam logic [7:0] MRK_APP0  = 8'hE0;
	localparam logic [7:0] MRK_APP1  = 8'hE1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_END        = 3'd1,
		ST_NO_FF      = 3'd2,
		ST_UNKNOWN    = 3'd3,
		ST_BAD_LEN    = 3'd4,
		ST_AFTER_STOP = 3'd5
	} status_t;

	typedef enum logic [10:0] {
		PH_WANT_FF   = 11'b000_0000_0001,
		PH_WANT_TYPE = 11'b000_0000_0010,
		PH_LEN_HI    = 11'b000_0000_0100,
		PH_LEN_LO    = 11'b000_0000_1000,
		PH_SKIP      = 11'b000_0001_0000,
		PH_E_LEN_HI  = 11'b000_0010_0000,
		PH_E_LEN_LO  = 11'b000_0100_0000,
		PH_E_SKIP    = 11'b000_1000_0000,
		PH_E_DATA    = 11'b001_0000_0000,
		PH_E_GOT_FF  = 11'b010_0000_0000,
		PH_STOPPED   = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [7:0]             len_hi;
		logic [15:0]            skip;
		logic [POS_WIDTH-1:0]   pos;
		logic [7:0]             marker;
		logic                   started;
	} scan_state_t;

endpackage

`default_nettype wire

// ===== rtl/jmss_step.sv =====
// Next-state and status logic for one stream byte.
`default_nettype none

module jmss_step (
	input  jmss_pkg::scan_state_t cur,
	input  logic [7:0]            data_byte,
	output jmss_pkg::scan_state_t nxt,
	output jmss_pkg::status_t     status
);

	jmss_pkg::phase_t  tp_phase;
	jmss_pkg::status_t tp_status;
	logic [15:0]       len;
	logic              len_short;
	logic              len_two;

	// marker type decode
	always_comb begin
		unique case (data_byte)
			jmss_pkg::MRK_SOI: begin
				tp_phase  = jmss_pkg::PH_WANT_FF;
				tp_status = jmss_pkg::ST_OK;
			end
			jmss_pkg::MRK_EOI: begin
				tp_phase  = jmss_pkg::PH_STOPPED;
				tp_status = jmss_pkg::ST_END;
			end
			jmss_pkg::MRK_SOS, jmss_pkg::MRK_SOF0, jmss_pkg::MRK_DHT: begin
				tp_phase  = jmss_pkg::PH_E_LEN_HI;
				tp_status = jmss_pkg::ST_OK;
			end
			jmss_pkg::MRK_DQT, jmss_pkg::MRK_APP0, jmss_pkg::MRK_APP1: begin
				tp_phase  = jmss_pkg::PH_LEN_HI;
				tp_status = jmss_pkg::ST_OK;
			end
			default: begin
				tp_phase  = jmss_pkg::PH_STOPPED;
				tp_status = jmss_pkg::ST_UNKNOWN;
			end
		endcase
	end

	assign len       = {cur.len_hi, data_byte};
	assign len_short = (len < 16'd2);
	assign len_two   = (len == 16'd2);

	always_comb begin
		nxt    = cur;
		status = jmss_pkg::ST_OK;

		// position saturates at all ones; first byte is index zero
		nxt.started = 1'b1;
		if (!cur.started) begin
			nxt.pos = '0;
		end else if (cur.pos != '1) begin
			nxt.pos = cur.pos + 1'b1;
		end

		unique case (cur.phase)
			jmss_pkg::PH_WANT_FF: begin
				if (data_byte == jmss_pkg::BYTE_FF) begin
					nxt.phase = jmss_pkg::PH_WANT_TYPE;
				end else begin
					nxt.phase = jmss_pkg::PH_STOPPED;
					status    = jmss_pkg::ST_NO_FF;
				end
			end
			jmss_pkg::PH_WANT_TYPE: begin
				nxt.marker = data_byte;
				nxt.phase  = tp_phase;
				status     = tp_status;
			end
			jmss_pkg::PH_LEN_HI, jmss_pkg::PH_E_LEN_HI: begin
				nxt.len_hi = data_byte;
				nxt.phase  = (cur.phase == jmss_pkg::PH_LEN_HI) ?
					jmss_pkg::PH_LEN_LO : jmss_pkg::PH_E_LEN_LO;
			end
			jmss_pkg::PH_LEN_LO, jmss_pkg::PH_E_LEN_LO: begin
				if (len_short) begin
					nxt.phase = jmss_pkg::PH_STOPPED;
					status    = jmss_pkg::ST_BAD_LEN;
				end else if (len_two) begin
					nxt.skip  = '0;
					nxt.phase = (cur.phase == jmss_pkg::PH_LEN_LO) ?
						jmss_pkg::PH_WANT_FF : jmss_pkg::PH_E_DATA;
				end else begin
					nxt.skip  = len - 16'd2;
					nxt.phase = (cur.phase == jmss_pkg::PH_LEN_LO) ?
						jmss_pkg::PH_SKIP : jmss_pkg::PH_E_SKIP;
				end
			end
			jmss_pkg::PH_SKIP, jmss_pkg::PH_E_SKIP: begin
				if (cur.skip <= 16'd1) begin
					nxt.skip  = '0;
					nxt.phase = (cur.phase == jmss_pkg::PH_SKIP) ?
						jmss_pkg::PH_WANT_FF : jmss_pkg::PH_E_DATA;
				end else begin
					nxt.skip = cur.skip - 16'd1;
				end
			end
			jmss_pkg::PH_E_DATA: begin
				if (data_byte == jmss_pkg::BYTE_FF) begin
					nxt.phase = jmss_pkg::PH_E_GOT_FF;
				end
			end
			jmss_pkg::PH_E_GOT_FF: begin
				// FF00 is a stuffed zero, FFFF is fill, anything else a marker
				if (data_byte == jmss_pkg::BYTE_00) begin
					nxt.phase = jmss_pkg::PH_E_DATA;
				end else if (data_byte != jmss_pkg::BYTE_FF) begin
					nxt.marker = data_byte;
					nxt.phase  = tp_phase;
					status     = tp_status;
				end
			end
			default: begin
				nxt.phase = jmss_pkg::PH_STOPPED;
				status    = jmss_pkg::ST_AFTER_STOP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/jpeg_marker_segment_scanner.sv =====
// JPEG marker segment scanner top level: input register, step logic, result register.
// A byte taken into the input register passes through the step logic into the result
// register when the scanner advances, that is, when no finished result is held by out_stall.
// Throughput: one byte per cycle while out_stall holds no result, set by the combinational step logic.
// While a finished result waits to be taken, the input register takes one more byte, then stalls.
// Reset (arst_n low, asynchronous): scanner waits for FF, position before index zero.
`default_nettype none

`include "jpeg_marker_segment_scanner_assert.svh"

module jpeg_marker_segment_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      byte_position,
	output logic [7:0]       marker_type,
	output logic             in_entropy
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  advance;
	logic                  in_fire;
	jmss_pkg::scan_state_t state_q;
	jmss_pkg::scan_state_t state_nxt;
	jmss_pkg::status_t     status_nxt;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
		end
	end

	jmss_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.nxt       (state_nxt),
		.status    (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= jmss_pkg::PH_WANT_FF;
			state_q.len_hi  <= '0;
			state_q.skip    <= '0;
			state_q.pos     <= '1;
			state_q.marker  <= '0;
			state_q.started <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status        <= status_nxt;
			byte_position <= 32'(state_nxt.pos);
			marker_type   <= state_nxt.marker;
			in_entropy    <= (state_nxt.phase == jmss_pkg::PH_E_DATA) ||
				(state_nxt.phase == jmss_pkg::PH_E_GOT_FF);
		end
	end

	// any non-ok status leaves the scanner stopped
	`JMSS_ASSERT_NEXT(a_err_stops, advance && (status_nxt != jmss_pkg::ST_OK), state_q.phase == jmss_pkg::PH_STOPPED)
	// stopped results never claim entropy data
	`JMSS_ASSERT_SAME(a_stop_no_entropy, out_valid && (status == jmss_pkg::ST_AFTER_STOP), !in_entropy)
	// an empty input register never holds off the sender
	`JMSS_ASSERT_SAME(a_empty_no_stall, !valid_s1, !in_stall)

endmodule

`default_nettype wire

// ===== dv/tb_jpeg_marker_segment_scanner.sv =====
// Self-checking testbench for the JPEG marker segment scanner: byte stream stimulus, scoreboard.
module tb_jpeg_marker_segment_scanner;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STREAM_ITEMS = 740;
	localparam int DRAIN_AT_A = 26;
	localparam int DRAIN_AT_B = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		jmss_pkg::status_t st;
		logic [31:0]       pos;
		logic [7:0]        mrk;
		logic              ent;
	} scan_result_t;

	typedef enum int {
		STOP_EOI,
		STOP_NO_FF,
		STOP_UNKNOWN,
		STOP_SHORT_PLAIN,
		STOP_SHORT_ENTROPY,
		STOP_UNKNOWN_IN_DATA
	} stop_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] byte_position;
	logic [7:0]  marker_type;
	logic        in_entropy;

	jpeg_marker_segment_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.byte_position(byte_position),
		.marker_type  (marker_type),
		.in_entropy   (in_entropy)
	);

	logic [7:0]   stream_q[$];
	scan_result_t expected_q[$];
	int           error_count = 0;
	int           sent_count = 0;
	int           send_gap = 0;
	int           hold_left = 0;
	logic         in_taken = 1'b0;
	logic         calm = 1'b0;

	// scanner state as the predictor sees it
	jmss_pkg::phase_t               scan_phase = jmss_pkg::PH_WANT_FF;
	logic [7:0]                     scan_len_hi = 8'h00;
	logic [15:0]                    scan_skip = 16'h0000;
	logic [jmss_pkg::POS_WIDTH-1:0] scan_pos = '1;
	logic [7:0]                     scan_marker = 8'h00;
	logic                           scan_started = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic jmss_pkg::status_t take_marker(input logic [7:0] b);
		scan_marker = b;
		case (b)
		jmss_pkg::MRK_SOI: begin
			scan_phase = jmss_pkg::PH_WANT_FF;
			return jmss_pkg::ST_OK;
		end
		jmss_pkg::MRK_EOI: begin
			scan_phase = jmss_pkg::PH_STOPPED;
			return jmss_pkg::ST_END;
		end
		jmss_pkg::MRK_SOS, jmss_pkg::MRK_SOF0, jmss_pkg::MRK_DHT: begin
			scan_phase = jmss_pkg::PH_E_LEN_HI;
			return jmss_pkg::ST_OK;
		end
		jmss_pkg::MRK_DQT, jmss_pkg::MRK_APP0, jmss_pkg::MRK_APP1: begin
			scan_phase = jmss_pkg::PH_LEN_HI;
			return jmss_pkg::ST_OK;
		end
		default: begin
			scan_phase = jmss_pkg::PH_STOPPED;
			return jmss_pkg::ST_UNKNOWN;
		end
		endcase
	endfunction

	function automatic jmss_pkg::status_t take_length(input logic [7:0] b,
		input bit entropy);
		logic [15:0] len;
		len = {scan_len_hi, b};
		if (len < 16'd2) begin
			scan_phase = jmss_pkg::PH_STOPPED;
			return jmss_pkg::ST_BAD_LEN;
		end
		if (len == 16'd2) begin
			scan_skip = 16'd0;
			scan_phase = entropy ? jmss_pkg::PH_E_DATA : jmss_pkg::PH_WANT_FF;
		end else begin
			scan_skip = len - 16'd2;
			scan_phase = entropy ? jmss_pkg::PH_E_SKIP : jmss_pkg::PH_SKIP;
		end
		return jmss_pkg::ST_OK;
	endfunction

	function automatic void take_skip(input jmss_pkg::phase_t next);
		if (scan_skip <= 16'd1) begin
			scan_skip = 16'd0;
			scan_phase = next;
		end else
			scan_skip = scan_skip - 16'd1;
	endfunction

	function automatic scan_result_t predict_scan(input logic [7:0] b);
		scan_result_t r;
		r.st = jmss_pkg::ST_OK;
		// first byte lands on index zero; later ones saturate at all ones
		if (!scan_started) begin
			scan_started = 1'b1;
			scan_pos = '0;
		end else if (scan_pos != '1)
			scan_pos = scan_pos + 1'b1;
		case (scan_phase)
		jmss_pkg::PH_WANT_FF: begin
			if (b == jmss_pkg::BYTE_FF)
				scan_phase = jmss_pkg::PH_WANT_TYPE;
			else begin
				scan_phase = jmss_pkg::PH_STOPPED;
				r.st = jmss_pkg::ST_NO_FF;
			end
		end
		jmss_pkg::PH_WANT_TYPE: r.st = take_marker(b);
		jmss_pkg::PH_LEN_HI: begin
			scan_len_hi = b;
			scan_phase = jmss_pkg::PH_LEN_LO;
		end
		jmss_pkg::PH_LEN_LO: r.st = take_length(b, 1'b0);
		jmss_pkg::PH_SKIP: take_skip(jmss_pkg::PH_WANT_FF);
		jmss_pkg::PH_E_LEN_HI: begin
			scan_len_hi = b;
			scan_phase = jmss_pkg::PH_E_LEN_LO;
		end
		jmss_pkg::PH_E_LEN_LO: r.st = take_length(b, 1'b1);
		jmss_pkg::PH_E_SKIP: take_skip(jmss_pkg::PH_E_DATA);
		jmss_pkg::PH_E_DATA: begin
			if (b == jmss_pkg::BYTE_FF)
				scan_phase = jmss_pkg::PH_E_GOT_FF;
		end
		jmss_pkg::PH_E_GOT_FF: begin
			// FF00 is an escaped zero, FFFF is fill, anything else a marker
			if (b == jmss_pkg::BYTE_00)
				scan_phase = jmss_pkg::PH_E_DATA;
			else if (b != jmss_pkg::BYTE_FF)
				r.st = take_marker(b);
		end
		default: begin
			scan_phase = jmss_pkg::PH_STOPPED;
			r.st = jmss_pkg::ST_AFTER_STOP;
		end
		endcase
		r.pos = 32'(scan_pos);
		r.mrk = scan_marker;
		r.ent = (scan_phase == jmss_pkg::PH_E_DATA || scan_phase == jmss_pkg::PH_E_GOT_FF);
		return r;
	endfunction

	// stream generation
	function automatic logic [7:0] pick_kind();
		case ($urandom_range(0, 9))
		0, 1: return jmss_pkg::MRK_SOI;
		2: return jmss_pkg::MRK_DQT;
		3: return jmss_pkg::MRK_APP0;
		4: return jmss_pkg::MRK_APP1;
		5, 6: return jmss_pkg::MRK_SOS;
		7: return jmss_pkg::MRK_SOF0;
		default: return jmss_pkg::MRK_DHT;
		endcase
	endfunction

	function automatic logic [7:0] pick_unknown(input bit in_data);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == jmss_pkg::MRK_SOI || b == jmss_pkg::MRK_EOI ||
			b == jmss_pkg::MRK_SOS || b == jmss_pkg::MRK_SOF0 ||
			b == jmss_pkg::MRK_DHT || b == jmss_pkg::MRK_DQT ||
			b == jmss_pkg::MRK_APP0 || b == jmss_pkg::MRK_APP1 ||
			(in_data && (b == jmss_pkg::BYTE_00 || b == jmss_pkg::BYTE_FF)));
		return b;
	endfunction

	function automatic void put_segment_body(input bit entropy);
		int len;
		if (!entropy && $urandom_range(0, 24) == 0)
			len = 256 + $urandom_range(0, 60);
		else
			len = $urandom_range(2, entropy ? 12 : 20);
		stream_q.push_back(8'(len >> 8));
		stream_q.push_back(8'(len));
		for (int i = 2; i < len; i++)
			stream_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_entropy_data();
		int units;
		units = $urandom_range(0, 16);
		for (int i = 0; i < units; i++) begin
			case ($urandom_range(0, 9))
			7: begin
				stream_q.push_back(jmss_pkg::BYTE_FF);
				stream_q.push_back(jmss_pkg::BYTE_00);
			end
			8, 9: begin
				stream_q.push_back(jmss_pkg::BYTE_FF);
				repeat ($urandom_range(1, 3)) stream_q.push_back(jmss_pkg::BYTE_FF);
				stream_q.push_back(jmss_pkg::BYTE_00);
			end
			default: stream_q.push_back(8'($urandom_range(0, 254)));
			endcase
		end
	endfunction

	// one well-formed marker, with entropy segments chained into the next marker
	function automatic void put_marker_run();
		logic [7:0] kind;
		bit         chained;
		kind = pick_kind();
		stream_q.push_back(jmss_pkg::BYTE_FF);
		do begin
			stream_q.push_back(kind);
			chained = (kind == jmss_pkg::MRK_SOS || kind == jmss_pkg::MRK_SOF0 ||
				kind == jmss_pkg::MRK_DHT);
			if (kind != jmss_pkg::MRK_SOI)
				put_segment_body(chained);
			if (chained) begin
				put_entropy_data();
				stream_q.push_back(jmss_pkg::BYTE_FF);
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
					stream_q.push_back(jmss_pkg::BYTE_FF);
				kind = pick_kind();
			end
		end while (chained);
	endfunction

	function automatic void put_stop();
		stop_kind_t how;
		how = stop_kind_t'($urandom_range(0, 5));
		case (how)
		STOP_EOI: begin
			stream_q.push_back(jmss_pkg::BYTE_FF);
			stream_q.push_back(jmss_pkg::MRK_EOI);
		end
		STOP_NO_FF: stream_q.push_back(8'($urandom_range(0, 254)));
		STOP_UNKNOWN: begin
			stream_q.push_back(jmss_pkg::BYTE_FF);
			stream_q.push_back(pick_unknown(1'b0));
		end
		STOP_SHORT_PLAIN: begin
			stream_q.push_back(jmss_pkg::BYTE_FF);
			stream_q.push_back($urandom_range(0, 1) ? jmss_pkg::MRK_DQT : jmss_pkg::MRK_APP1);
			stream_q.push_back(jmss_pkg::BYTE_00);
			stream_q.push_back(8'($urandom_range(0, 1)));
		end
		STOP_SHORT_ENTROPY: begin
			stream_q.push_back(jmss_pkg::BYTE_FF);
			stream_q.push_back($urandom_range(0, 1) ? jmss_pkg::MRK_SOS : jmss_pkg::MRK_DHT);
			stream_q.push_back(jmss_pkg::BYTE_00);
			stream_q.push_back(8'($urandom_range(0, 1)));
		end
		default: begin
			stream_q.push_back(jmss_pkg::BYTE_FF);
			stream_q.push_back(jmss_pkg::MRK_SOF0);
			stream_q.push_back(jmss_pkg::BYTE_00);
			stream_q.push_back(8'd2);
			put_entropy_data();
			stream_q.push_back(jmss_pkg::BYTE_FF);
			stream_q.push_back(pick_unknown(1'b1));
		end
		endcase
		// sticky: everything after this is reported as after stop
		stream_q.push_back(jmss_pkg::BYTE_00);
		stream_q.push_back(jmss_pkg::BYTE_FF);
		repeat (6) stream_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin
		if ($urandom_range(0, 127) == 0)
			calm <= !calm;
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (send_gap != 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (stream_q.size() != 0 &&
				!((sent_count == DRAIN_AT_A || sent_count == DRAIN_AT_B) &&
				expected_q.size() != 0)) begin
				in_valid <= 1'b1;
				data_byte <= stream_q.pop_front();
				sent_count++;
				send_gap = pick_gap();
			end else
				in_valid <= 1'b0;
		end
	end

	// result-side back-pressure
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= 1'b0;
			hold_left = pick_gap();
		end
	end

	// scoreboard: results are checked before the same edge's input is predicted
	always @(posedge clk) begin
		scan_result_t want;
		scan_result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.st = jmss_pkg::status_t'(status);
				got.pos = byte_position;
				got.mrk = marker_type;
				got.ent = in_entropy;
				if (expected_q.size() == 0)
					note_error($sformatf("unexpected transaction: status %0d pos %0d marker %02h ent %0b",
						got.st, got.pos, got.mrk, got.ent));
				else begin
					want = expected_q.pop_front();
					if (got !== want)
						note_error($sformatf(
							"mismatch: status %0d/%0d pos %0d/%0d marker %02h/%02h ent %0b/%0b (exp/act)",
							want.st, got.st, want.pos, got.pos, want.mrk, got.mrk,
							want.ent, got.ent));
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_scan(data_byte));
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	initial begin
		// SOI, APP0 with no payload, DQT skipping an FF, SOF0 into entropy data
		// with escaped zero, fill bytes and a fill run ending on a marker
		stream_q = '{8'hFF, jmss_pkg::MRK_SOI,
			8'hFF, jmss_pkg::MRK_APP0, 8'h00, 8'h02,
			8'hFF, jmss_pkg::MRK_DQT, 8'h00, 8'h03, 8'hFF,
			8'hFF, jmss_pkg::MRK_SOF0, 8'h00, 8'h03, 8'h00,
			8'h00, 8'hFF, 8'h00, 8'h5A, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
			jmss_pkg::MRK_SOI};
		while (stream_q.size() < STREAM_ITEMS)
			put_marker_run();
		put_stop();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stream_q.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("tb_jpeg_marker_segment_scanner: done, clean");
		else
			$display("tb_jpeg_marker_segment_scanner: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_jpeg_marker_segment_scanner: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jmss_pkg.sv
rtl/jmss_step.sv
rtl/jpeg_marker_segment_scanner.sv
dv/tb_jpeg_marker_segment_scanner.sv
